>>> hdl/mcfe_pkg.sv
`default_nettype none

package mcfe_pkg;

   // field widths fixed by the word format
   localparam int TIME_W      = 32;
   localparam int LEN_W       = 16;
   localparam int ALPHA_W     = 8;
   localparam int OUT_CH_W    = 6;
   localparam int KIND_W      = 2;

   localparam int CHANNELS_DEFAULT = 64;
   localparam int MAX_RESULTS      = 64;
   localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // one channel's envelope as held in the channel RAM
   typedef struct packed {
      logic [TIME_W-1:0]  start_time;
      logic [LEN_W-1:0]   in_len;
      logic [LEN_W-1:0]   hold_len;
      logic [LEN_W-1:0]   out_len;
      logic [LEN_W-1:0]   gap_len;
      logic               repeat_flag;
      logic [ALPHA_W-1:0] peak_alpha;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mcfe_ram.sv
`default_nettype none

module mcfe_ram
   import mcfe_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = CHANNELS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [idx_width(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]            wr_data,
   input  wire logic                        rd_en,
   input  wire logic [idx_width(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/multichannel_fade_envelope.sv
`default_nettype none

// Multichannel fade envelope. Each request word carries the time in ticks.
// A start word loads a channel (named, or the first free one) with fade-in,
// hold, fade-out, gap, repeat and peak alpha and answers with the channel, or
// status 1 if none is free. A remove word frees one channel or all of them and
// answers with one word. A frame word walks the channels from lowest to
// highest and sends one word per live channel with its alpha; the final word
// carries last, and at most 64 words are sent though every channel is updated.
// Alpha is 0 before the start, rises linearly to the peak, holds, then falls
// linearly; at the end the channel frees itself or restarts after the gap.
// The block takes one request word at a time and holds req_stall high until
// every response word of it has been handed to the output register.
// A start on any channel searches from channel 0 upward for the first free
// one. A frame reads the entry of each live channel; a channel on a ramp also
// goes through the shared 8-step restoring divider (one quotient bit a cycle).
// Back-pressure on rsp_ holds the sequence until the output register is free.
// The channel RAM holds no reset state; the active flags are flip-flops.

module multichannel_fade_envelope
   import mcfe_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [TIME_W-1:0]   req_now,
   input  wire logic [OUT_CH_W-1:0] req_channel,
   input  wire logic                req_any_channel,
   input  wire logic [LEN_W-1:0]    req_fade_in,
   input  wire logic [LEN_W-1:0]    req_hold_time,
   input  wire logic [LEN_W-1:0]    req_fade_out,
   input  wire logic [LEN_W-1:0]    req_gap,
   input  wire logic                req_repeat_req,
   input  wire logic [ALPHA_W-1:0]  req_peak,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [OUT_CH_W-1:0]      rsp_out_channel,
   output logic [ALPHA_W-1:0]       rsp_alpha,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam int CH_W    = idx_width(CHANNELS);
   localparam int REM_W   = LEN_W + ALPHA_W;
   localparam int DSH_W   = REM_W - 1;
   localparam int STEP_W  = $clog2(ALPHA_W);
   localparam int B_W     = LEN_W + 1;
   localparam int E_W     = LEN_W + 2;

   localparam logic [CH_W-1:0]   LAST_IDX = CH_W'(CHANNELS - 1);
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(ALPHA_W - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FREE  = 4'd1;   // search for a free channel
   localparam logic [3:0] S_WRITE = 4'd2;   // load the channel RAM
   localparam logic [3:0] S_PUSH  = 4'd3;   // hand over final word
   localparam logic [3:0] S_RD    = 4'd4;   // frame: read channel entry
   localparam logic [3:0] S_CMP   = 4'd5;   // elapsed time and phase ends
   localparam logic [3:0] S_CLS   = 4'd6;   // pick phase
   localparam logic [3:0] S_MUL   = 4'd7;   // ramp numerator
   localparam logic [3:0] S_DIV   = 4'd8;   // one quotient bit per cycle
   localparam logic [3:0] S_EMIT  = 4'd9;   // queue alpha word
   localparam logic [3:0] S_NEXT  = 4'd10;  // advance channel

   // control state
   logic [3:0]           state_ff, state_in;
   logic [CHANNELS-1:0]  active_ff, active_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload / datapath
   logic [CH_W-1:0]      idx_ff, idx_in;
   chan_entry_type       req_ent_ff, req_ent_in;
   logic [TIME_W-1:0]    t_ff, t_in;
   logic                 before_ff, before_in;
   logic [B_W-1:0]       b_ff, b_in;
   logic [E_W-1:0]       e_ff, e_in;
   logic [LEN_W-1:0]     x_ff, x_in;
   logic [DSH_W-1:0]     dsh_ff, dsh_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [OUT_CH_W-1:0]  pend_ch_ff, pend_ch_in;
   logic [ALPHA_W-1:0]   pend_alpha_ff, pend_alpha_in;
   logic                 pend_status_ff, pend_status_in;
   logic [OUT_CH_W-1:0]  rsp_ch_ff, rsp_ch_in;
   logic [ALPHA_W-1:0]   rsp_alpha_ff, rsp_alpha_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   // channel RAM
   logic                 ram_wr_en;
   logic [CH_W-1:0]      ram_wr_addr;
   chan_entry_type       ram_wr_data;
   logic                 ram_rd_en;
   logic [ENTRY_W-1:0]   ram_rd_data;
   chan_entry_type       ent;

   logic                 req_accept;
   logic                 out_free;
   logic [CH_W-1:0]      req_idx;
   logic                 req_in_range;
   logic [TIME_W:0]      now_diff;
   logic [TIME_W:0]      restart_sum;
   logic [TIME_W-1:0]    restart_time;
   logic                 div_ge;
   logic [REM_W-1:0]     div_sub;

   mcfe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign ent = chan_entry_type'(ram_rd_data);

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_idx      = CH_W'(req_channel);
   assign req_in_range = (32'(req_channel) < 32'(CHANNELS));

   // t = now - start; borrow means the envelope has not begun
   assign now_diff = {1'b0, req_ent_ff.start_time} - {1'b0, ent.start_time};

   // restart time, saturated at the top of the tick range
   assign restart_sum  = {1'b0, req_ent_ff.start_time} + (TIME_W + 1)'(ent.gap_len);
   assign restart_time = restart_sum[TIME_W] ? {TIME_W{1'b1}} : restart_sum[TIME_W-1:0];

   // shared divider step
   assign div_ge  = (rem_ff >= {1'b0, dsh_ff});
   assign div_sub = rem_ff - {1'b0, dsh_ff};

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      pend_valid_in  = pend_valid_ff;
      n_in           = n_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      idx_in         = idx_ff;
      req_ent_in     = req_ent_ff;
      t_in           = t_ff;
      before_in      = before_ff;
      b_in           = b_ff;
      e_in           = e_ff;
      x_in           = x_ff;
      dsh_in         = dsh_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      alpha_in       = alpha_ff;
      pend_ch_in     = pend_ch_ff;
      pend_alpha_in  = pend_alpha_ff;
      pend_status_in = pend_status_ff;
      rsp_ch_in      = rsp_ch_ff;
      rsp_alpha_in   = rsp_alpha_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = req_ent_ff;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_ent_in.start_time  = req_now;
               req_ent_in.in_len      = req_fade_in;
               req_ent_in.hold_len    = req_hold_time;
               req_ent_in.out_len     = req_fade_out;
               req_ent_in.gap_len     = req_gap;
               req_ent_in.repeat_flag = req_repeat_req;
               req_ent_in.peak_alpha  = req_peak;
               pend_alpha_in  = '0;
               pend_status_in = STATUS_OK;
               pend_ch_in     = '0;
               unique case (req_kind)
                  KIND_START: begin
                     if (req_any_channel) begin
                        idx_in   = '0;
                        state_in = S_FREE;
                     end else if (req_in_range) begin
                        idx_in   = req_idx;
                        state_in = S_WRITE;
                     end else begin
                        pend_status_in = STATUS_FULL;
                        pend_valid_in  = 1'b1;
                        state_in       = S_PUSH;
                     end
                  end
                  KIND_REMOVE: begin
                     if (req_any_channel) begin
                        active_in = '0;
                     end else begin
                        pend_ch_in = req_channel;
                        if (req_in_range) begin
                           active_in[req_idx] = 1'b0;
                        end
                     end
                     pend_valid_in = 1'b1;
                     state_in      = S_PUSH;
                  end
                  KIND_FRAME: begin
                     idx_in   = '0;
                     n_in     = '0;
                     state_in = S_RD;
                  end
                  default: begin
                     // unused code: dropped, no word
                  end
               endcase
            end
         end

         S_FREE: begin
            if (!active_ff[idx_ff]) begin
               state_in = S_WRITE;
            end else if (idx_ff == LAST_IDX) begin
               pend_status_in = STATUS_FULL;
               pend_valid_in  = 1'b1;
               state_in       = S_PUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_WRITE: begin
            ram_wr_en         = 1'b1;
            active_in[idx_ff] = 1'b1;
            pend_ch_in        = OUT_CH_W'(idx_ff);
            pend_valid_in     = 1'b1;
            state_in          = S_PUSH;
         end

         S_PUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = pend_ch_ff;
               rsp_alpha_in  = pend_alpha_ff;
               rsp_status_in = pend_status_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_RD: begin
            if (active_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_CMP;
            end else begin
               state_in = S_NEXT;
            end
         end

         S_CMP: begin
            t_in      = now_diff[TIME_W-1:0];
            before_in = now_diff[TIME_W];
            b_in      = B_W'(ent.in_len) + B_W'(ent.hold_len);
            e_in      = E_W'(ent.in_len) + E_W'(ent.hold_len) + E_W'(ent.out_len);
            state_in  = S_CLS;
         end

         S_CLS: begin
            if (before_ff) begin
               alpha_in = '0;
               state_in = S_EMIT;
            end else if (t_ff < TIME_W'(ent.in_len)) begin
               // rising ramp: t * peak / fade-in
               x_in     = t_ff[LEN_W-1:0];
               dsh_in   = {ent.in_len, {(ALPHA_W-1){1'b0}}};
               state_in = S_MUL;
            end else if (t_ff <= TIME_W'(b_ff)) begin
               alpha_in = ent.peak_alpha;
               state_in = S_EMIT;
            end else if (t_ff <= TIME_W'(e_ff)) begin
               // falling ramp: (end - t) * peak / fade-out
               x_in     = LEN_W'(e_ff - t_ff[E_W-1:0]);
               dsh_in   = {ent.out_len, {(ALPHA_W-1){1'b0}}};
               state_in = S_MUL;
            end else if (!ent.repeat_flag) begin
               active_in[idx_ff] = 1'b0;
               state_in          = S_NEXT;
            end else begin
               // restart; from the new start t is zero or negative, so alpha
               // is the peak only for an immediate restart with no fade-in
               ram_wr_en              = 1'b1;
               ram_wr_data            = ent;
               ram_wr_data.start_time = restart_time;
               if ((ent.gap_len != '0) && (req_ent_ff.start_time != {TIME_W{1'b1}})) begin
                  alpha_in = '0;
               end else if (ent.in_len == '0) begin
                  alpha_in = ent.peak_alpha;
               end else begin
                  alpha_in = '0;
               end
               state_in = S_EMIT;
            end
         end

         S_MUL: begin
            rem_in   = REM_W'(x_ff) * REM_W'(ent.peak_alpha);
            step_in  = STEP_TOP;
            alpha_in = '0;
            state_in = S_DIV;
         end

         S_DIV: begin
            rem_in   = div_ge ? div_sub : rem_ff;
            alpha_in = {alpha_ff[ALPHA_W-2:0], div_ge};
            dsh_in   = dsh_ff >> 1;
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (n_ff < RES_CNT_W'(MAX_RESULTS)) begin
               // the queued word goes out once a later one proves it not last
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_ch_in     = pend_ch_ff;
                     rsp_alpha_in  = pend_alpha_ff;
                     rsp_status_in = pend_status_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_ch_in     = OUT_CH_W'(idx_ff);
                  pend_alpha_in  = alpha_ff;
                  pend_status_in = STATUS_OK;
                  n_in           = n_ff + 1'b1;
                  state_in       = S_NEXT;
               end
            end else begin
               state_in = S_NEXT;
            end
         end

         S_NEXT: begin
            if (idx_ff == LAST_IDX) begin
               state_in = pend_valid_ff ? S_PUSH : S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      req_ent_ff     <= req_ent_in;
      t_ff           <= t_in;
      before_ff      <= before_in;
      b_ff           <= b_in;
      e_ff           <= e_in;
      x_ff           <= x_in;
      dsh_ff         <= dsh_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      alpha_ff       <= alpha_in;
      pend_ch_ff     <= pend_ch_in;
      pend_alpha_ff  <= pend_alpha_in;
      pend_status_ff <= pend_status_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_alpha_ff   <= rsp_alpha_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_alpha       = rsp_alpha_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   // an accepted word of a defined kind leaves the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_kind == KIND_START || req_kind == KIND_REMOVE ||
                     req_kind == KIND_FRAME) |=> req_stall)
      else $error("request accepted without going busy");

   // frame never queues more than the result limit
   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("frame result count beyond limit");

   // remainder stays below twice the shifted divisor, else quotient overflows
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < {dsh_ff, 1'b0})
      else $error("divider remainder out of range");

   // a failed start is a lone word on channel 0 with zero alpha
   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_last && rsp_alpha == '0 && rsp_out_channel == '0)
      else $error("malformed start failure word");

   // a queued word only exists once a result has been counted or in a final push
   a_pend_count: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && (state_ff == S_NEXT || state_ff == S_RD) |-> n_ff != '0)
      else $error("queued frame word without count");

endmodule

`default_nettype wire

>>> dv/fade_env_checker.sv
`default_nettype none

module fade_env_checker
   import mcfe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [TIME_W-1:0]   req_now,
   input  wire logic [OUT_CH_W-1:0] req_channel,
   input  wire logic                req_any_channel,
   input  wire logic [LEN_W-1:0]    req_fade_in,
   input  wire logic [LEN_W-1:0]    req_hold_time,
   input  wire logic [LEN_W-1:0]    req_fade_out,
   input  wire logic [LEN_W-1:0]    req_gap,
   input  wire logic                req_repeat_req,
   input  wire logic [ALPHA_W-1:0]  req_peak,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [OUT_CH_W-1:0] rsp_out_channel,
   input  wire logic [ALPHA_W-1:0]  rsp_alpha,
   input  wire logic                rsp_status,
   input  wire logic                rsp_last,
   output int                       mismatch_count,
   output int                       words_pending,
   output int                       words_checked
);

   localparam int NCH = CHANNELS_DEFAULT;
   localparam longint unsigned TIME_MAX = 64'h0000_0000_FFFF_FFFF;

   typedef struct {
      logic [OUT_CH_W-1:0] chan;
      logic [ALPHA_W-1:0]  alpha;
      logic                status;
      logic                last;
   } rsp_word_type;

   chan_entry_type env [NCH];
   bit             live [NCH];
   rsp_word_type   due_q [$];
   int             errs = 0;
   int             seen = 0;

   // alpha of one live channel at time now; returns 0 if the channel frees itself
   function automatic bit channel_alpha(input int c, input logic [TIME_W-1:0] now,
                                        output logic [ALPHA_W-1:0] alpha);
      longint unsigned nw, s, t, a, b, e, pk, q;
      nw = now;
      alpha = '0;
      for (int round = 0; round < 2; round++) begin
         s  = env[c].start_time;
         if (nw < s) return 1'b1;
         t  = nw - s;
         a  = env[c].in_len;
         b  = a + env[c].hold_len;
         e  = b + env[c].out_len;
         pk = env[c].peak_alpha;
         if (t < a) begin
            q = (t * pk) / a;
            alpha = q[ALPHA_W-1:0];
            return 1'b1;
         end
         if (t <= b) begin
            alpha = pk[ALPHA_W-1:0];
            return 1'b1;
         end
         if (t <= e) begin
            q = ((e - t) * pk) / env[c].out_len;
            alpha = q[ALPHA_W-1:0];
            return 1'b1;
         end
         if (!env[c].repeat_flag) begin
            live[c] = 1'b0;
            return 1'b0;
         end
         // restart after the gap, clipped at the top of the time range
         q = nw + env[c].gap_len;
         if (q > TIME_MAX) q = TIME_MAX;
         env[c].start_time = q[TIME_W-1:0];
      end
      return 1'b1;
   endfunction

   function automatic void predict_words(input logic [KIND_W-1:0] kind,
                                         input logic [TIME_W-1:0] now,
                                         input logic [OUT_CH_W-1:0] chan,
                                         input logic any,
                                         input logic [LEN_W-1:0] fi, ht, fo, gp,
                                         input logic rp,
                                         input logic [ALPHA_W-1:0] pk);
      int sel;
      int n;
      logic [ALPHA_W-1:0] alpha;
      sel = NCH;
      n   = 0;
      case (kind)
         KIND_START: begin
            if (any) begin
               for (int c = 0; c < NCH; c++) begin
                  if (!live[c]) begin
                     sel = c;
                     break;
                  end
               end
            end else if (chan < NCH) begin
               sel = chan;
            end
            if (sel >= NCH) begin
               due_q.push_back('{OUT_CH_W'(0), ALPHA_W'(0), STATUS_FULL, 1'b1});
            end else begin
               env[sel] = '{start_time: now, in_len: fi, hold_len: ht, out_len: fo,
                            gap_len: gp, repeat_flag: rp, peak_alpha: pk};
               live[sel] = 1'b1;
               due_q.push_back('{OUT_CH_W'(sel), ALPHA_W'(0), STATUS_OK, 1'b1});
            end
         end
         KIND_REMOVE: begin
            if (any) begin
               foreach (live[i]) live[i] = 1'b0;
               due_q.push_back('{OUT_CH_W'(0), ALPHA_W'(0), STATUS_OK, 1'b1});
            end else begin
               if (chan < NCH) live[chan] = 1'b0;
               due_q.push_back('{chan, ALPHA_W'(0), STATUS_OK, 1'b1});
            end
         end
         KIND_FRAME: begin
            // every live channel is updated, only the first MAX_RESULTS reported
            for (int c = 0; c < NCH; c++) begin
               if (live[c] && channel_alpha(c, now, alpha) && n < MAX_RESULTS) begin
                  due_q.push_back('{OUT_CH_W'(c), alpha, STATUS_OK, 1'b0});
                  n++;
               end
            end
            if (n > 0) due_q[due_q.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         foreach (live[i]) live[i] = 1'b0;
         due_q.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_words(req_kind, req_now, req_channel, req_any_channel, req_fade_in,
                          req_hold_time, req_fade_out, req_gap, req_repeat_req, req_peak);
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               $error("response word with nothing due: out_channel %0d alpha %0d",
                      rsp_out_channel, rsp_alpha);
               errs++;
            end else begin
               w = due_q.pop_front();
               seen++;
               check_field("out_channel", w.chan, rsp_out_channel);
               check_field("alpha", w.alpha, rsp_alpha);
               check_field("status", w.status, rsp_status);
               check_field("last", w.last, rsp_last);
            end
         end
      end
      mismatch_count <= errs;
      words_pending  <= due_q.size();
      words_checked  <= seen;
   end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

// Stimulus and verdict for the fade envelope block. The checker beside the
// block predicts every response word and counts mismatches; this module only
// feeds request words, applies back-pressure and reports.

module tb_top;
   import mcfe_pkg::*;

   localparam int NCH          = CHANNELS_DEFAULT;
   localparam int ITEM_TARGET  = 250;   // request words over the whole run
   localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
   localparam int TAIL_CYCLES  = 1000;  // wait after the drain for stray words

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind        = KIND_NONE;
   logic [TIME_W-1:0]   req_now         = '0;
   logic [OUT_CH_W-1:0] req_channel     = '0;
   logic                req_any_channel = 1'b0;
   logic [LEN_W-1:0]    req_fade_in     = '0;
   logic [LEN_W-1:0]    req_hold_time   = '0;
   logic [LEN_W-1:0]    req_fade_out    = '0;
   logic [LEN_W-1:0]    req_gap         = '0;
   logic                req_repeat_req  = 1'b0;
   logic [ALPHA_W-1:0]  req_peak        = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [OUT_CH_W-1:0] rsp_out_channel;
   logic [ALPHA_W-1:0]  rsp_alpha;
   logic                rsp_status;
   logic                rsp_last;

   int mismatch_count;
   int words_pending;
   int words_checked;

   // request word tallies (ignored kinds are not counted)
   int words_sent   = 0;
   int starts_sent  = 0;
   int frames_sent  = 0;
   int removes_sent = 0;

   bit sender_idles = 1'b1;
   bit hold_wanted  = 1'b0;   // raised by the stimulus once the table is full
   bit hold_done    = 1'b0;

   multichannel_fade_envelope #(.CHANNELS(NCH)) i_dut (.*);

   fade_env_checker i_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop, well beyond the slowest legal run
   initial begin
      #36000000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls, a quiet window, and one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= (cyc < 3000 || cyc >= 6000) && ($urandom_range(0, 99) < 27);
      end
   end

   // one word on the request channel; valid is held until the word is taken
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                            input logic [OUT_CH_W-1:0] chan, input logic any,
                            input logic [LEN_W-1:0] fi, ht, fo, gp,
                            input logic rp, input logic [ALPHA_W-1:0] pk);
      while (sender_idles && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_now         <= now;
      req_channel     <= chan;
      req_any_channel <= any;
      req_fade_in     <= fi;
      req_hold_time   <= ht;
      req_fade_out    <= fo;
      req_gap         <= gp;
      req_repeat_req  <= rp;
      req_peak        <= pk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind != KIND_NONE) words_sent++;
   endtask

   task automatic start_env(input logic [TIME_W-1:0] now, input logic [OUT_CH_W-1:0] chan,
                            input logic any, input logic [LEN_W-1:0] fi, ht, fo, gp,
                            input logic rp, input logic [ALPHA_W-1:0] pk);
      send_word(KIND_START, now, chan, any, fi, ht, fo, gp, rp, pk);
      starts_sent++;
   endtask

   // fields a remove or frame word does not use carry junk so every bit moves
   task automatic remove_env(input logic [OUT_CH_W-1:0] chan, input logic any);
      send_word(KIND_REMOVE, $urandom(), chan, any, LEN_W'($urandom()), LEN_W'($urandom()),
                LEN_W'($urandom()), LEN_W'($urandom()), 1'($urandom()),
                ALPHA_W'($urandom()));
      removes_sent++;
   endtask

   task automatic frame_at(input logic [TIME_W-1:0] now);
      send_word(KIND_FRAME, now, OUT_CH_W'($urandom()), 1'($urandom()), LEN_W'($urandom()),
                LEN_W'($urandom()), LEN_W'($urandom()), LEN_W'($urandom()),
                1'($urandom()), ALPHA_W'($urandom()));
      frames_sent++;
   endtask

   task automatic noise_word();
      send_word(KIND_NONE, $urandom(), OUT_CH_W'($urandom()), 1'($urandom()),
                LEN_W'($urandom()), LEN_W'($urandom()), LEN_W'($urandom()),
                LEN_W'($urandom()), 1'($urandom()), ALPHA_W'($urandom()));
   endtask

   // mostly short spans so frames land in every phase; some zero, some huge
   function automatic logic [LEN_W-1:0] pick_span();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LEN_W'($urandom());
         2:       return '1;
         default: return LEN_W'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic random_start(input logic [TIME_W-1:0] now);
      start_env(now, OUT_CH_W'($urandom_range(0, NCH - 1)), ($urandom_range(0, 2) == 0),
                pick_span(), pick_span(), pick_span(), pick_span(), 1'($urandom()),
                ALPHA_W'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [TIME_W-1:0] tbase;
      int                ofs;
      int                target;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      frame_at(32'd0);                    // nothing live: no words back
      noise_word();                       // unused kind is ignored
      start_env(32'd1000, 6'd0, 1'b0, 16'd100, 16'd50, 16'd100, 16'd0, 1'b0, 8'd255);
      start_env(32'd1000, 6'd63, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 8'd200);
      // widest spans, start lies ahead of the next frames
      start_env(32'd2000, 6'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
      // near the top of the time range, repeating with a long gap
      start_env(32'hFFFF_FF00, 6'd2, 1'b0, 16'd16, 16'd16, 16'd16, 16'hFFFF, 1'b1, 8'd128);
      frame_at(32'd1000);                 // ramp at zero, zero-length envelope at peak
      frame_at(32'd1050);                 // mid ramp; zero-length one ends and frees
      frame_at(32'd1100);                 // hold starts exactly at fade-in end
      frame_at(32'd1150);                 // hold end is inclusive
      frame_at(32'd1200);                 // fade-out
      frame_at(32'd1250);                 // fade-out end gives 0
      frame_at(32'd1251);                 // past the end without repeat: freed
      frame_at(32'hFFFF_FF40);            // restart clipped at the top of time
      frame_at(32'hFFFF_FFFF);
      start_env(32'd5000, 6'd3, 1'b0, 16'd10, 16'd0, 16'd10, 16'd5, 1'b1, 8'd100);
      frame_at(32'd5021);                 // restart lands in the future: 0
      frame_at(32'd5031);
      // overwrite a live channel; zero gap restarts straight into hold
      start_env(32'd6000, 6'd3, 1'b0, 16'd0, 16'd5, 16'd0, 16'd0, 1'b1, 8'd77);
      frame_at(32'd6006);
      remove_env(6'd3, 1'b0);
      remove_env(6'd40, 1'b0);            // removing an idle channel still answers
      remove_env(6'd17, 1'b1);            // remove all reports channel 0
      frame_at(32'd7000);

      // ---- random part ----
      target = ITEM_TARGET;

      // fill every channel with ramps, reject one more, then frame the lot
      // while the receiver holds off so the block backs up onto its input
      tbase = $urandom();
      for (int i = 0; i < NCH; i++)
         start_env(tbase + i, OUT_CH_W'($urandom()), 1'b1,
                   LEN_W'($urandom_range(1, 60)), LEN_W'($urandom_range(0, 20)),
                   LEN_W'($urandom_range(1, 60)), LEN_W'($urandom_range(0, 30)),
                   1'($urandom()), ALPHA_W'($urandom_range(0, 255)));
      start_env(tbase, OUT_CH_W'($urandom()), 1'b1, pick_span(), pick_span(), pick_span(),
                pick_span(), 1'($urandom()), ALPHA_W'($urandom()));
      hold_wanted = 1'b1;
      for (int k = 0; k < 6; k++) frame_at(tbase + 20 * k + $urandom_range(0, 15));
      remove_env(OUT_CH_W'($urandom()), 1'b1);

      while (words_sent < target) begin
         // a stretch of back-to-back request words
         sender_idles = !(words_sent >= 150 && words_sent < 200);
         case ($urandom_range(0, 9))
            0:       tbase = $urandom();
            1:       tbase = 32'hFFFF_FF00 | TIME_W'($urandom_range(0, 255));
            default: tbase = tbase + TIME_W'($urandom_range(50, 400));
         endcase
         repeat ($urandom_range(1, 5)) random_start(tbase + TIME_W'($urandom_range(0, 20)));
         ofs = 0;
         repeat ($urandom_range(2, 8)) begin
            ofs += $urandom_range(0, 30);
            if ($urandom_range(0, 9) == 0)
               frame_at(tbase - TIME_W'($urandom_range(1, 50)));
            else
               frame_at(tbase + TIME_W'(ofs));
         end
         if ($urandom_range(0, 3) == 0)
            remove_env(OUT_CH_W'($urandom()), ($urandom_range(0, 4) == 0));
         if ($urandom_range(0, 5) == 0) noise_word();
         if ($urandom_range(0, 19) == 0) frame_at($urandom());
      end
      req_valid <= 1'b0;

      // let the checker see the last word, drain, then give stray words time
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d request words: %0d start, %0d frame, %0d remove; %0d response words compared",
               words_sent, starts_sent, frames_sent, removes_sent, words_checked);
      $display("full channel table with one rejected start, %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (words_pending != 0)
         $error("%0d response words never arrived", words_pending);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hdl/mcfe_pkg.sv
hdl/mcfe_ram.sv
hdl/multichannel_fade_envelope.sv
dv/fade_env_checker.sv
dv/tb_top.sv
